// ===== rtl/kdi_pkg.sv =====
// kdi_pkg: shared constants, types and codes of the kernel deinterlacer
// depends on nothing
`default_nettype none

package kdi_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int WIN_LINES   = 8;
    localparam int LANE_W      = $clog2(WIN_LINES);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int DIM_W       = (COL_W + 1 > 12) ? COL_W + 1 : 12;
    localparam int ROW_W       = 12;
    localparam int PEND_W      = DIM_W + 2;
    localparam int PIX_W       = 8;
    localparam int WORD_W      = WIN_LINES * PIX_W;
    localparam int MAX_HEIGHT  = 2048;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int ACC_W       = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_WAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd6;

    localparam logic [PIX_W-1:0] CLAMP_LO    = 8'd16;
    localparam logic [PIX_W-1:0] LUMA_HI     = 8'd235;
    localparam logic [PIX_W-1:0] CHROMA_HI   = 8'd240;
    localparam logic [PIX_W-1:0] MAP_LUMA    = 8'd235;
    localparam logic [PIX_W-1:0] MAP_CHROMA  = 8'd128;

    // floor(v / 1000) for 0 <= v < 2^18 as (v * RECIP_M) >> RECIP_SH
    localparam int RECIP_SH = 28;
    localparam logic [18:0] RECIP_M = 19'd268436;

    typedef enum logic [1:0] {
        KIND_CENTER,
        KIND_NEIGHBOR,
        KIND_INTERP
    } kind_t;

    typedef struct packed {
        logic                   field_order;
        logic [7:0]             motion_threshold;
        logic                   sharp_kernel;
        logic                   two_way;
        logic                   motion_map;
        logic [11:0]            luma_width;
        logic [11:0]            luma_height;
    } cfg_t;

    typedef struct packed {
        logic                   emit;
        logic                   wr;
        logic [COL_W-1:0]       col;
        logic [LANE_W-1:0]      wr_lane;
        logic [LANE_W-1:0]      base_lane;
        logic                   use_in;
        kind_t                  kind;
        logic                   chroma;
        logic                   ff;
        logic                   last;
        logic [PIX_W-1:0]       cur;
        logic [PIX_W-1:0]       prev;
    } item_t;

    typedef struct packed {
        logic                   emit;
        logic                   use_kernel;
        logic                   chroma;
        logic                   last;
        logic [PIX_W-1:0]       direct;
        logic [PIX_W:0]         s1;
        logic [PIX_W:0]         s0;
        logic [PIX_W+1:0]       s2;
        logic [PIX_W:0]         s3;
        logic [PIX_W+1:0]       s4;
    } kin_t;

endpackage

`default_nettype wire

// ===== rtl/kernel_deinterlacer_top.sv =====
// kernel_deinterlacer_top: motion-adaptive kernel deinterlacer for one plane
// depends on kdi_pkg, kdi_ctrl, kdi_window, kdi_kernel
//
// input channel (in_valid/in_ready) takes one item per cycle unless stalled:
// a raster-order plane pixel with its previous-frame pixel, or a drain request
// output channel (out_valid/out_ready) gives one deinterlaced pixel per item
// that causes one; outputs lag the input by four rows, drain items flush
// the last four rows once the plane is complete
// throughput: one item per clock unless stalled; out_valid rises once the item
// has passed the line store read, which lands at the accepting edge, the tap
// gather, the kernel sum (divide and clamp follow it) and the output register
// the line stores are two 2048 x 64 rams, one word per column holding all
// eight lines, read and written back once per pixel
// reset clears position, drain count, plane latches and the pipeline; the
// line stores are not cleared and need no clearing pass
// when the receiver stalls the whole pipeline holds and in_ready falls
// configuration is written through cfg_we/cfg_index/cfg_data while idle
`default_nettype none

module kernel_deinterlacer_top import kdi_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [PIX_W-1:0]      cur_pixel,
    input  wire logic [PIX_W-1:0]      prev_pixel,
    input  wire logic                  is_chroma,
    input  wire logic                  first_frame,
    input  wire logic                  plane_start,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_W-1:0]           out_pixel,
    output logic                       last_of_plane
);

    cfg_t             cfg_reg;
    logic             adv, fire;
    item_t            item;
    logic             item_valid;
    kin_t             kin;
    logic             kin_valid;
    logic             res_valid, res_last;
    logic [PIX_W-1:0] res_pixel;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_order      <= 1'b1;
            cfg_reg.motion_threshold <= 8'd10;
            cfg_reg.sharp_kernel     <= 1'b0;
            cfg_reg.two_way          <= 1'b0;
            cfg_reg.motion_map       <= 1'b0;
            cfg_reg.luma_width       <= 12'd720;
            cfg_reg.luma_height      <= 12'd576;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIELD_ORDER: cfg_reg.field_order      <= cfg_data[0];
                CFG_THRESHOLD:   cfg_reg.motion_threshold <= cfg_data[7:0];
                CFG_SHARP:       cfg_reg.sharp_kernel     <= cfg_data[0];
                CFG_TWO_WAY:     cfg_reg.two_way          <= cfg_data[0];
                CFG_MAP:         cfg_reg.motion_map       <= cfg_data[0];
                CFG_WIDTH:       cfg_reg.luma_width       <= cfg_data[11:0];
                CFG_HEIGHT:      cfg_reg.luma_height      <= cfg_data[11:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign fire     = in_valid && adv;

    kdi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fire        (fire),
        .action      (action),
        .cur_pixel   (cur_pixel),
        .prev_pixel  (prev_pixel),
        .is_chroma   (is_chroma),
        .first_frame (first_frame),
        .plane_start (plane_start),
        .item        (item),
        .item_valid  (item_valid)
    );

    kdi_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .adv        (adv),
        .item       (item),
        .item_valid (item_valid),
        .kin_reg    (kin),
        .kin_valid  (kin_valid)
    );

    kdi_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .adv       (adv),
        .kin_valid (kin_valid),
        .kin       (kin),
        .res_valid (res_valid),
        .res_pixel (res_pixel),
        .res_last  (res_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pixel_reg <= res_pixel;
            out_last_reg  <= res_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pixel     = out_pixel_reg;
    assign last_of_plane = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/kdi_ram.sv =====
// kdi_ram: simple dual-port synchronous ram with registered read
// depends on nothing
`default_nettype none

module kdi_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kdi_ctrl.sv =====
// kdi_ctrl: raster position, plane latches, drain count and row classification
// depends on kdi_pkg
`default_nettype none

module kdi_ctrl import kdi_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             fire,
    input  wire logic             action,
    input  wire logic [PIX_W-1:0] cur_pixel,
    input  wire logic [PIX_W-1:0] prev_pixel,
    input  wire logic             is_chroma,
    input  wire logic             first_frame,
    input  wire logic             plane_start,
    output item_t                 item,
    output logic                  item_valid
);

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  pw_reg, pw_next;
    logic [ROW_W-1:0]  ph_reg, ph_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              active_reg, active_next;
    logic              ff_reg, ff_next;
    logic              chroma_reg, chroma_next;

    logic              start, pix_ok, drain_ok, emit_pix;
    logic [DIM_W-1:0]  lw;
    logic [ROW_W-1:0]  lh;
    logic [ROW_W-1:0]  eff_row, out_row, row_inc;
    logic [COL_W-1:0]  eff_col;
    logic [DIM_W-1:0]  eff_pw, col_inc;
    logic [ROW_W-1:0]  eff_ph;
    logic              eff_chroma, eff_ff;
    logic [ROW_W:0]    r13, h13, o13;
    logic              is_edge, is_center;

    always_comb
    begin
        lw = DIM_W'(cfg.luma_width);
        if (lw < DIM_W'(8))
        begin
            lw = DIM_W'(8);
        end
        else if (lw > DIM_W'(MAX_WIDTH))
        begin
            lw = DIM_W'(MAX_WIDTH);
        end
        lh = cfg.luma_height;
        if (lh < ROW_W'(16))
        begin
            lh = ROW_W'(16);
        end
        else if (lh > ROW_W'(MAX_HEIGHT))
        begin
            lh = ROW_W'(MAX_HEIGHT);
        end
    end

    assign start    = !action && plane_start;
    assign pix_ok   = !action && (plane_start || active_reg);
    assign drain_ok = action && (pend_reg != '0);

    assign eff_row    = start ? '0 : row_reg;
    assign eff_col    = start ? '0 : col_reg;
    assign eff_chroma = start ? is_chroma : chroma_reg;
    assign eff_ff     = start ? first_frame : ff_reg;
    assign eff_pw     = start ? (is_chroma ? (lw >> 1) : lw) : pw_reg;
    assign eff_ph     = start ? (is_chroma ? (lh >> 1) : lh) : ph_reg;

    assign emit_pix = pix_ok && (eff_row >= ROW_W'(4));
    assign out_row  = action ? row_reg : eff_row - ROW_W'(4);
    assign col_inc  = DIM_W'(eff_col) + DIM_W'(1);
    assign row_inc  = eff_row + ROW_W'(1);

    // row classification
    assign r13 = {1'b0, out_row};
    assign h13 = {1'b0, eff_ph};
    assign o13 = (ROW_W+1)'(cfg.field_order);
    assign is_edge = (r13 == o13) || (r13 == o13 + (ROW_W+1)'(2))
                  || (r13 == h13 + o13 - (ROW_W+1)'(4))
                  || (r13 == h13 + o13 - (ROW_W+1)'(2));
    assign is_center = (out_row[0] != cfg.field_order)
                    || (r13 < o13 + (ROW_W+1)'(4))
                    || (r13 > h13 + o13 - (ROW_W+1)'(6));

    always_comb
    begin
        item.emit      = emit_pix || drain_ok;
        item.wr        = pix_ok;
        item.col       = eff_col;
        item.wr_lane   = eff_row[LANE_W-1:0];
        item.base_lane = action ? row_reg[LANE_W-1:0] + LANE_W'(4) : eff_row[LANE_W-1:0];
        item.use_in    = !action;
        item.kind      = is_edge ? KIND_NEIGHBOR : (is_center ? KIND_CENTER : KIND_INTERP);
        item.chroma    = eff_chroma;
        item.ff        = eff_ff;
        item.last      = drain_ok && (pend_reg == PEND_W'(1));
        item.cur       = cur_pixel;
        item.prev      = prev_pixel;
        item_valid     = fire && (pix_ok || drain_ok);
    end

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        pw_next     = pw_reg;
        ph_next     = ph_reg;
        pend_next   = pend_reg;
        active_next = active_reg;
        ff_next     = ff_reg;
        chroma_next = chroma_reg;
        if (fire && pix_ok)
        begin
            pw_next     = eff_pw;
            ph_next     = eff_ph;
            ff_next     = eff_ff;
            chroma_next = eff_chroma;
            active_next = 1'b1;
            if (start)
            begin
                pend_next = '0;
            end
            if (col_inc >= eff_pw)
            begin
                col_next = '0;
                row_next = row_inc;
                if (row_inc >= eff_ph)
                begin
                    active_next = 1'b0;
                    pend_next   = PEND_W'({eff_pw, 2'b00});
                    row_next    = eff_ph - ROW_W'(4);
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = eff_row;
            end
        end
        else if (fire && drain_ok)
        begin
            pend_next = pend_reg - PEND_W'(1);
            if (col_inc >= pw_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            pw_reg     <= '0;
            ph_reg     <= '0;
            pend_reg   <= '0;
            active_reg <= 1'b0;
            ff_reg     <= 1'b0;
            chroma_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            pw_reg     <= pw_next;
            ph_reg     <= ph_next;
            pend_reg   <= pend_next;
            active_reg <= active_next;
            ff_reg     <= ff_next;
            chroma_reg <= chroma_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kdi_window.sv =====
// kdi_window: line store read-modify-write with forwarding, tap gather,
// motion test and tap sums; depends on kdi_pkg and kdi_ram
`default_nettype none

module kdi_window import kdi_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  adv,
    input  wire item_t item,
    input  wire logic  item_valid,
    output kin_t       kin_reg,
    output logic       kin_valid
);

    item_t             s1_reg;
    logic              s1_valid_reg;
    logic [WORD_W-1:0] ram_cur, ram_prev, cur_word, prev_word;
    logic [WORD_W-1:0] wr_cur, wr_prev;
    logic [COL_W-1:0]  fw_addr_reg;
    logic [WORD_W-1:0] fw_cur_reg, fw_prev_reg;
    logic              fw_valid_reg;
    logic              wr_en;
    logic              kin_valid_reg;
    logic [PIX_W-1:0]  c [9];
    logic [PIX_W-1:0]  p [9];
    logic [PIX_W-1:0]  d3, d4, d5;
    logic              motion;
    kin_t              kin_next;

    assign wr_en = adv && s1_valid_reg && s1_reg.wr;

    kdi_ram #(.DEPTH(MAX_WIDTH), .WIDTH(WORD_W)) u_cur_ram (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (item.col),
        .rd_data (ram_cur),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.col),
        .wr_data (wr_cur)
    );

    kdi_ram #(.DEPTH(MAX_WIDTH), .WIDTH(WORD_W)) u_prev_ram (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (item.col),
        .rd_data (ram_prev),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.col),
        .wr_data (wr_prev)
    );

    // newest write to this column wins over the ram read
    assign cur_word  = (fw_valid_reg && fw_addr_reg == s1_reg.col) ? fw_cur_reg : ram_cur;
    assign prev_word = (fw_valid_reg && fw_addr_reg == s1_reg.col) ? fw_prev_reg : ram_prev;

    always_comb
    begin
        wr_cur  = cur_word;
        wr_prev = prev_word;
        wr_cur[s1_reg.wr_lane*PIX_W +: PIX_W]  = s1_reg.cur;
        wr_prev[s1_reg.wr_lane*PIX_W +: PIX_W] = s1_reg.prev;
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            c[k] = cur_word[LANE_W'(s1_reg.base_lane + LANE_W'(k))*PIX_W +: PIX_W];
            p[k] = prev_word[LANE_W'(s1_reg.base_lane + LANE_W'(k))*PIX_W +: PIX_W];
        end
        c[8] = s1_reg.use_in ? s1_reg.cur  : c[0];
        p[8] = s1_reg.use_in ? s1_reg.prev : p[0];
    end

    assign d3 = (p[3] > c[3]) ? p[3] - c[3] : c[3] - p[3];
    assign d4 = (p[4] > c[4]) ? p[4] - c[4] : c[4] - p[4];
    assign d5 = (p[5] > c[5]) ? p[5] - c[5] : c[5] - p[5];
    assign motion = (cfg.motion_threshold == '0) || s1_reg.ff
                 || (d3 > cfg.motion_threshold) || (d4 > cfg.motion_threshold)
                 || (d5 > cfg.motion_threshold);

    always_comb
    begin
        kin_next.emit       = s1_valid_reg && s1_reg.emit;
        kin_next.chroma     = s1_reg.chroma;
        kin_next.last       = s1_reg.last;
        kin_next.use_kernel = 1'b0;
        kin_next.direct     = c[4];
        case (s1_reg.kind)
            KIND_NEIGHBOR:
            begin
                kin_next.direct = cfg.field_order ? c[3] : c[5];
            end
            KIND_INTERP:
            begin
                if (motion)
                begin
                    if (cfg.motion_map)
                    begin
                        kin_next.direct = s1_reg.chroma ? MAP_CHROMA : MAP_LUMA;
                    end
                    else
                    begin
                        kin_next.use_kernel = 1'b1;
                    end
                end
            end
            default:
            begin
                kin_next.direct = c[4];
            end
        endcase
        kin_next.s1 = (PIX_W+1)'(c[3]) + (PIX_W+1)'(c[5]);
        kin_next.s3 = (PIX_W+1)'(c[1]) + (PIX_W+1)'(c[7]);
        if (cfg.two_way)
        begin
            kin_next.s0 = (PIX_W+1)'(c[4]) + (PIX_W+1)'(p[4]);
            kin_next.s2 = (PIX_W+2)'(c[2]) + (PIX_W+2)'(c[6])
                        + (PIX_W+2)'(p[2]) + (PIX_W+2)'(p[6]);
            kin_next.s4 = (PIX_W+2)'(c[0]) + (PIX_W+2)'(c[8])
                        + (PIX_W+2)'(p[0]) + (PIX_W+2)'(p[8]);
        end
        else
        begin
            kin_next.s0 = (PIX_W+1)'(p[4]);
            kin_next.s2 = (PIX_W+2)'(p[2]) + (PIX_W+2)'(p[6]);
            kin_next.s4 = (PIX_W+2)'(p[0]) + (PIX_W+2)'(p[8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            kin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= item_valid;
            kin_valid_reg <= kin_next.emit;
            if (wr_en)
            begin
                fw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= item;
            kin_reg <= kin_next;
            if (wr_en)
            begin
                fw_addr_reg <= s1_reg.col;
                fw_cur_reg  <= wr_cur;
                fw_prev_reg <= wr_prev;
            end
        end
    end

    // reset-cleared copy of the emit bit
    assign kin_valid = kin_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/kdi_kernel.sv =====
// kdi_kernel: weighted tap sum, floor division and clamp, two stages
// depends on kdi_pkg
`default_nettype none

module kdi_kernel import kdi_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             adv,
    input  wire logic             kin_valid,
    input  wire kin_t             kin,
    output logic                  res_valid,
    output logic [PIX_W-1:0]      res_pixel,
    output logic                  res_last
);

    logic signed [ACC_W-1:0] s1, s0, s2, s3, s4, v_next;
    logic signed [ACC_W-1:0] v_reg;
    logic                    valid_reg, sharp_reg, chroma_reg, last_reg, use_reg;
    logic [PIX_W-1:0]        direct_reg;
    logic signed [ACC_W-1:0] lo_lim, hi_lim;
    logic [36:0]             prod;
    logic [PIX_W-1:0]        quot, hi_val, kval;

    assign s1 = ACC_W'($signed({1'b0, kin.s1}));
    assign s0 = ACC_W'($signed({1'b0, kin.s0}));
    assign s2 = ACC_W'($signed({1'b0, kin.s2}));
    assign s3 = ACC_W'($signed({1'b0, kin.s3}));
    assign s4 = ACC_W'($signed({1'b0, kin.s4}));

    always_comb
    begin
        if (cfg.sharp_kernel)
        begin
            v_next = ACC_W'(526) * s1 + ACC_W'(170) * s0 - ACC_W'(116) * s2
                   - ACC_W'(26) * s3 + ACC_W'(31) * s4;
        end
        else
        begin
            v_next = (s1 <<< 3) + (s0 <<< 1) - s2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= kin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg      <= v_next;
            sharp_reg  <= cfg.sharp_kernel;
            chroma_reg <= kin.chroma;
            last_reg   <= kin.last;
            use_reg    <= kin.use_kernel;
            direct_reg <= kin.direct;
        end
    end

    // clamp limits scaled by the divisor
    always_comb
    begin
        if (sharp_reg)
        begin
            lo_lim = ACC_W'(16000);
            hi_lim = chroma_reg ? ACC_W'(241000) : ACC_W'(236000);
        end
        else
        begin
            lo_lim = ACC_W'(256);
            hi_lim = chroma_reg ? ACC_W'(3856) : ACC_W'(3776);
        end
    end

    assign prod   = 37'(v_reg[17:0]) * 37'(RECIP_M);
    assign quot   = sharp_reg ? prod[RECIP_SH +: PIX_W] : v_reg[4 +: PIX_W];
    assign hi_val = chroma_reg ? CHROMA_HI : LUMA_HI;

    always_comb
    begin
        if (v_reg < lo_lim)
        begin
            kval = CLAMP_LO;
        end
        else if (v_reg >= hi_lim)
        begin
            kval = hi_val;
        end
        else
        begin
            kval = quot;
        end
    end

    assign res_valid = valid_reg;
    assign res_pixel = use_reg ? kval : direct_reg;
    assign res_last  = last_reg;

endmodule

`default_nettype wire

// ===== bench/tb_kernel_deinterlacer_top.sv =====
// testbench for kernel_deinterlacer_top: random planes of pixels and drains,
// checked item by item against a behavioral scoreboard
// depends on kdi_pkg and kernel_deinterlacer_top
`default_nettype none

module tb_kernel_deinterlacer_top;
    import kdi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    class deint_scoreboard;
        bit [7:0] cur_mem[WIN_LINES][MAX_WIDTH];
        bit [7:0] prev_mem[WIN_LINES][MAX_WIDTH];
        bit       field_order;
        bit [7:0] threshold;
        bit       sharp;
        bit       two_way;
        bit       paint;
        bit [11:0] luma_w;
        bit [11:0] luma_h;
        int       row_pos;
        int       col_pos;
        int       drain_left;
        bit       ff_hold;
        bit       chroma_hold;
        bit       plane_on;
        int       pw;
        int       ph;
        bit [8:0] expected_pixels[$];
        int       errors;

        function new();
            field_order = 1'b1;
            threshold = 8'd10;
            luma_w = 12'd720;
            luma_h = 12'd576;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FIELD_ORDER: field_order = d[0];
                CFG_THRESHOLD:   threshold = d[7:0];
                CFG_SHARP:       sharp = d[0];
                CFG_TWO_WAY:     two_way = d[0];
                CFG_MAP:         paint = d[0];
                CFG_WIDTH:       luma_w = d;
                CFG_HEIGHT:      luma_h = d;
                default: ;
            endcase
        endfunction

        function int plane_cols(bit chroma);
            int w;
            w = luma_w < 8 ? 8 : (luma_w > MAX_WIDTH ? MAX_WIDTH : luma_w);
            return chroma ? w >> 1 : w;
        endfunction

        function int plane_rows(bit chroma);
            int h;
            h = luma_h < 16 ? 16 : (luma_h > MAX_HEIGHT ? MAX_HEIGHT : luma_h);
            return chroma ? h >> 1 : h;
        endfunction

        function int tap(bit from_prev, int row, int x, int in_row, int in_val);
            if (row == in_row)
                return in_val;
            return from_prev ? prev_mem[row % WIN_LINES][x % MAX_WIDTH]
                             : cur_mem[row % WIN_LINES][x % MAX_WIDTH];
        endfunction

        function int absdiff(int a, int b);
            return a > b ? a - b : b - a;
        endfunction

        function int deinterlace(int r, int x, int in_row, int in_cur, int in_prev);
            int o;
            int c[9];
            int p[9];
            int v;
            int hi;
            bit moving;
            o = field_order;
            hi = chroma_hold ? CHROMA_HI : LUMA_HI;
            if (r == o || r == 2 + o || r == ph - 4 + o || r == ph - 2 + o)
                return tap(0, r + 1 - 2 * o, x, in_row, in_cur);
            if ((r & 1) != o || r < 4 + o || r > ph - 6 + o)
                return tap(0, r, x, in_row, in_cur);
            for (int k = 0; k < 9; k++)
            begin
                c[k] = tap(0, r + k - 4, x, in_row, in_cur);
                p[k] = tap(1, r + k - 4, x, in_row, in_prev);
            end
            moving = threshold == 0 || ff_hold || absdiff(p[4], c[4]) > threshold
                     || absdiff(p[3], c[3]) > threshold || absdiff(p[5], c[5]) > threshold;
            if (!moving)
                return c[4];
            if (paint)
                return chroma_hold ? MAP_CHROMA : MAP_LUMA;
            if (sharp)
            begin
                if (two_way)
                    v = 526 * (c[3] + c[5]) + 170 * (c[4] + p[4])
                        - 116 * (c[2] + c[6] + p[2] + p[6]) - 26 * (c[1] + c[7])
                        + 31 * (c[0] + c[8] + p[0] + p[8]);
                else
                    v = 526 * (c[3] + c[5]) + 170 * p[4] - 116 * (p[2] + p[6])
                        - 26 * (c[1] + c[7]) + 31 * (p[0] + p[8]);
                v = (v + 200000) / 1000 - 200;
            end
            else
            begin
                if (two_way)
                    v = 8 * (c[3] + c[5]) + 2 * (c[4] + p[4]) - c[2] - c[6] - p[2] - p[6];
                else
                    v = 8 * (c[3] + c[5]) + 2 * p[4] - p[2] - p[6];
                v = (v + 2048) / 16 - 128;
            end
            if (v > hi)
                v = hi;
            if (v < int'(CLAMP_LO))
                v = CLAMP_LO;
            return v;
        endfunction

        function void note_item(bit act, bit [7:0] cur, bit [7:0] prv, bit chroma,
                                bit ff, bit start);
            int v;
            if (act == ACT_DRAIN)
            begin
                if (drain_left == 0)
                    return;
                v = deinterlace(row_pos, col_pos, -1, 0, 0);
                expected_pixels.push_back({drain_left == 1, v[7:0]});
                drain_left--;
                col_pos++;
                if (col_pos >= pw)
                begin
                    col_pos = 0;
                    row_pos++;
                end
                return;
            end
            if (start)
            begin
                chroma_hold = chroma;
                pw = plane_cols(chroma);
                ph = plane_rows(chroma);
                ff_hold = ff;
                row_pos = 0;
                col_pos = 0;
                drain_left = 0;
                plane_on = 1;
            end
            else if (!plane_on)
                return;
            if (row_pos >= 4)
            begin
                v = deinterlace(row_pos - 4, col_pos, row_pos, cur, prv);
                expected_pixels.push_back({1'b0, v[7:0]});
            end
            cur_mem[row_pos % WIN_LINES][col_pos % MAX_WIDTH] = cur;
            prev_mem[row_pos % WIN_LINES][col_pos % MAX_WIDTH] = prv;
            col_pos++;
            if (col_pos >= pw)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= ph)
                begin
                    plane_on = 0;
                    drain_left = 4 * pw;
                    row_pos = ph - 4;
                end
            end
        endfunction

        function void check_pixel(logic [7:0] pix, logic last);
            bit [8:0] want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output pixel %0d last %0b", pix, last);
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want[7:0] || last !== want[8])
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: expected %0d last %0b, got %0d last %0b",
                             want[7:0], want[8], pix, last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = 1'b0;
    logic [PIX_W-1:0]      cur_pixel = '0;
    logic [PIX_W-1:0]      prev_pixel = '0;
    logic                  is_chroma = 1'b0;
    logic                  first_frame = 1'b0;
    logic                  plane_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  last_of_plane;

    deint_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    bit steady;
    int item_total;

    kernel_deinterlacer_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .cur_pixel(cur_pixel), .prev_pixel(prev_pixel),
        .is_chroma(is_chroma), .first_frame(first_frame), .plane_start(plane_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_pixel(out_pixel), .last_of_plane(last_of_plane)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || $urandom_range(99) >= recv_idle_pct;
        if (rst_n && in_valid && in_ready)
            sb.note_item(action, cur_pixel, prev_pixel, is_chroma, first_frame, plane_start);
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(out_pixel, last_of_plane);
    end

    initial
    begin
        #20ms;
        $display("FAIL kernel_deinterlacer_top");
        $finish;
    end

    task automatic send_item(logic act, logic [7:0] cur, logic [7:0] prv, logic chroma,
                             logic ff, logic start);
        in_valid <= 1'b1;
        action <= act;
        cur_pixel <= cur;
        prev_pixel <= prv;
        is_chroma <= chroma;
        first_frame <= ff;
        plane_start <= start;
        do
            @(posedge clk);
        while (!in_ready);
        item_total++;
        if (!steady && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // the caller drops cfg_we after its last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_pixel(logic start, logic chroma, logic ff);
        logic [7:0] cur;
        logic [7:0] prv;
        int delta;
        cur = 8'($urandom);
        delta = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 24);
        prv = $urandom_range(1) ? 8'(cur + delta > 255 ? 255 : cur + delta)
                                : 8'(cur < delta ? 0 : cur - delta);
        if ($urandom_range(0, 15) == 0)
            prv = 8'($urandom);
        send_item(ACT_PIXEL, cur, prv, start ? chroma : 1'($urandom_range(1)),
                  start ? ff : 1'($urandom_range(1)), start);
    endtask

    task automatic drain_item();
        send_item(ACT_DRAIN, 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic run_plane(logic chroma, logic ff, int abort_at);
        int n;
        int drains;
        n = sb.plane_cols(chroma) * sb.plane_rows(chroma);
        steady = $urandom_range(0, 4) == 0;
        for (int i = 0; i < n; i++)
        begin
            if (i == abort_at)
                return;
            if (i != 0 && $urandom_range(0, 60) == 0)
                drain_item();
            send_pixel(i == 0, chroma, ff);
        end
        if ($urandom_range(0, 6) == 0)
            send_pixel(1'b0, chroma, ff);
        drains = 4 * sb.plane_cols(chroma);
        case ($urandom_range(0, 7))
            0: drains = drains + $urandom_range(1, 3);
            1: drains = $urandom_range(0, drains);
            default: ;
        endcase
        repeat (drains) drain_item();
        steady = 1'b0;
    endtask

    task automatic setup_phase(int ph);
        write_reg(CFG_FIELD_ORDER, CFG_DATA_W'($urandom));
        write_reg(CFG_THRESHOLD, ph == 0 ? 12'd0 : ph == 1 ? 12'd255
                                 : ph == 2 ? 12'hfff : CFG_DATA_W'($urandom_range(1, 40)));
        write_reg(CFG_SHARP, {(CFG_DATA_W-1)'($urandom_range(0, 2047)), ph[0]});
        write_reg(CFG_TWO_WAY, {(CFG_DATA_W-1)'($urandom_range(0, 2047)), ph[1]});
        write_reg(CFG_MAP, {(CFG_DATA_W-1)'($urandom_range(0, 2047)), ph == 4 || ph == 7});
        case (ph)
            2:       write_reg(CFG_WIDTH, 12'hfff);
            5:       write_reg(CFG_WIDTH, 12'd3);
            0, 6:    write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, 8)));
            default: write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(8, 20)));
        endcase
        case (ph)
            2:       write_reg(CFG_HEIGHT, 12'd0);
            5:       write_reg(CFG_HEIGHT, 12'hfff);
            3:       write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 16)));
            default: write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(16, 24)));
        endcase
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase_goal;
        send_idle_pct = 21;
        recv_idle_pct = 47;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing active yet: idle drain and stray pixel give no output
        drain_item();
        send_pixel(1'b0, 1'b0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 21;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setup_phase(ph);
            if (ph == 0)
            begin
                // smallest-width chroma plane with first frame, then a restart cut short
                run_plane(1'b1, 1'b1, -1);
                run_plane(1'b0, 1'b0, $urandom_range(1, 60));
            end
            phase_goal = item_total + 120;
            // very large planes are cut short, and one in ten of the others at random
            while (item_total < phase_goal)
                run_plane(1'($urandom_range(1)), $urandom_range(0, 3) == 0,
                          (ph == 2 || ph == 5) ? $urandom_range(100, 200)
                          : $urandom_range(0, 9) == 0 ? $urandom_range(1, 200) : -1);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("PASS kernel_deinterlacer_top");
        else
            $display("FAIL kernel_deinterlacer_top");
        $finish;
    end
endmodule

`default_nettype wire
